@@ rtl/rbb_pkg.sv @@
// ----------------------------------------------------------------------------
// rbb_pkg
// Shared types, codes and store size of the ring byte buffer: commands, status
// codes and the job record passed from the front end to the back end.
// ----------------------------------------------------------------------------
package rbb_pkg;

  localparam int DEPTH = 256;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_EXIT  = 2'd3
  } cmd_t;

  typedef logic [2:0] status_t;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_BAD_LEN  = 3'd1;
  localparam status_t ST_EXITING  = 3'd2;
  localparam status_t ST_TOO_LONG = 3'd3;
  localparam status_t ST_BLOCK    = 3'd4;

  localparam int QDEPTH = 4;

  typedef struct packed {
    logic       is_read;
    status_t    status;
    logic [7:0] len;
    logic [7:0] start;
    logic [8:0] fill;
  } job_t;

endpackage

@@ rtl/rbb_ram.sv @@
// ----------------------------------------------------------------------------
// rbb_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module rbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

@@ rtl/rbb_queue.sv @@
// ----------------------------------------------------------------------------
// rbb_queue
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rbb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rbb_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output rbb_pkg::job_t head_job
);
  import rbb_pkg::*;

  localparam int QAW = $clog2(QDEPTH);

  job_t           mem_r [QDEPTH];
  logic [QAW-1:0] wptr_r, wptr_nxt;
  logic [QAW-1:0] rptr_r, rptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == (QAW+1)'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

endmodule

@@ rtl/rbb_front.sv @@
// ----------------------------------------------------------------------------
// rbb_front
// Front end: accepts commands, checks them, stores write chunk bytes, keeps
// the indices and fill count, and queues one job per result-bearing command.
// ----------------------------------------------------------------------------
module rbb_front #(
  parameter int MAX_CHUNK = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_cmd,
  input  logic [7:0]                        in_chunk_length,
  input  logic [7:0]                        in_data_byte,
  input  logic                              in_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [8:0]                        cfg_data,
  output logic [8:0]                        eff_len,
  output logic                              ram_wr_en,
  output logic [$clog2(rbb_pkg::DEPTH)-1:0] ram_wr_addr,
  output logic [7:0]                        ram_wr_data,
  output logic                              q_push,
  output rbb_pkg::job_t                     q_job,
  input  logic                              q_full,
  input  logic                              rd_done
);
  import rbb_pkg::*;

  localparam int         AW        = $clog2(DEPTH);
  localparam logic [8:0] LEN_RESET = (DEPTH < 256) ? 9'(DEPTH) : 9'd256;
  localparam logic [8:0] MAXC      = 9'(MAX_CHUNK);
  localparam int         OW        = $clog2(QDEPTH + 2);

  logic [8:0]    len_r, len_nxt;
  logic [7:0]    ri_r, ri_nxt;
  logic [7:0]    wi_r, wi_nxt;
  logic [7:0]    tw_r, tw_nxt;
  logic [8:0]    count_r, count_nxt;
  logic [7:0]    run_cnt_r, run_cnt_nxt;
  logic          run_act_r, run_act_nxt;
  logic          run_ok_r, run_ok_nxt;
  logic          exit_r, exit_nxt;
  logic [OW-1:0] rd_out_r, rd_out_nxt;

  logic          accept;
  cmd_t          cmd;
  logic [8:0]    clen;
  logic [8:0]    room;
  logic [8:0]    chk_room;
  status_t       chk;
  status_t       wst;
  logic [7:0]    ti;
  logic [7:0]    ti_next;
  logic [8:0]    ti_inc;
  logic [7:0]    cnt;
  logic [7:0]    cnt_n;
  logic          ok;
  logic          store_ok;
  logic [8:0]    ri_sum;
  logic          cfg_take;
  logic [8:0]    cfg_clamped;

  assign cmd       = cmd_t'(in_cmd);
  assign accept    = in_valid && !in_stall;
  assign in_stall  = q_full || ((cmd == CMD_WRITE) && (rd_out_r != '0));
  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && (cfg_data != 9'd0);
  assign cfg_clamped = (32'(cfg_data) > 32'(DEPTH)) ? 9'(DEPTH) : cfg_data;
  assign eff_len   = len_r;

  assign clen     = {1'b0, in_chunk_length};
  assign room     = len_r - count_r;
  assign chk_room = (cmd == CMD_WRITE) ? room : count_r;

  always_comb begin
    if (clen == 9'd0) begin
      chk = ST_BAD_LEN;
    end else if (exit_r) begin
      chk = ST_EXITING;
    end else if ((clen > len_r) || (clen > MAXC)) begin
      chk = ST_TOO_LONG;
    end else if (clen > chk_room) begin
      chk = ST_BLOCK;
    end else begin
      chk = ST_OK;
    end
  end

  assign ti       = run_act_r ? tw_r : wi_r;
  assign cnt      = run_act_r ? run_cnt_r : 8'd0;
  assign ok       = run_act_r ? run_ok_r : 1'b1;
  assign store_ok = ok && (chk == ST_OK) && (cnt < in_chunk_length);
  assign ti_inc   = {1'b0, ti} + 9'd1;
  assign ti_next  = (ti_inc >= len_r) ? 8'd0 : ti_inc[7:0];
  assign cnt_n    = (cnt != 8'd255) ? cnt + 8'd1 : cnt;
  assign ri_sum   = {1'b0, ri_r} + clen;

  always_comb begin
    wst = chk;
    if ((chk == ST_OK) && ((cnt_n != in_chunk_length) || !store_ok)) begin
      wst = ST_BAD_LEN;
    end
  end

  assign ram_wr_en   = accept && (cmd == CMD_WRITE) && store_ok;
  assign ram_wr_addr = AW'(ti);
  assign ram_wr_data = in_data_byte;

  always_comb begin
    len_nxt     = len_r;
    ri_nxt      = ri_r;
    wi_nxt      = wi_r;
    tw_nxt      = tw_r;
    count_nxt   = count_r;
    run_cnt_nxt = run_cnt_r;
    run_act_nxt = run_act_r;
    run_ok_nxt  = run_ok_r;
    exit_nxt    = exit_r;
    q_push      = 1'b0;
    q_job       = '0;

    if (cfg_take) begin
      len_nxt     = cfg_clamped;
      ri_nxt      = '0;
      wi_nxt      = '0;
      tw_nxt      = '0;
      count_nxt   = '0;
      run_cnt_nxt = '0;
      run_act_nxt = 1'b0;
      run_ok_nxt  = 1'b0;
    end else if (accept) begin
      run_act_nxt = 1'b0;
      run_ok_nxt  = 1'b0;
      run_cnt_nxt = '0;
      unique case (cmd)
        CMD_WRITE: begin
          if (!in_last) begin
            run_act_nxt = 1'b1;
            run_ok_nxt  = store_ok;
            run_cnt_nxt = cnt_n;
            tw_nxt      = store_ok ? ti_next : ti;
          end else begin
            q_push       = 1'b1;
            q_job.status = wst;
            q_job.fill   = count_r;
            if (wst == ST_OK) begin
              wi_nxt     = ti_next;
              count_nxt  = count_r + clen;
              q_job.fill = count_r + clen;
            end
          end
        end
        CMD_READ: begin
          q_push       = 1'b1;
          q_job.status = chk;
          q_job.fill   = count_r;
          if (chk == ST_OK) begin
            q_job.is_read = 1'b1;
            q_job.len     = in_chunk_length;
            q_job.start   = ri_r;
            q_job.fill    = count_r - clen;
            count_nxt     = count_r - clen;
            ri_nxt        = (ri_sum >= len_r) ? 8'(ri_sum - len_r) : ri_sum[7:0];
          end
        end
        CMD_CLEAR: begin
          ri_nxt       = '0;
          wi_nxt       = '0;
          tw_nxt       = '0;
          count_nxt    = '0;
          q_push       = 1'b1;
          q_job.status = ST_OK;
          q_job.fill   = '0;
        end
        CMD_EXIT: begin
          exit_nxt     = 1'b1;
          q_push       = 1'b1;
          q_job.status = ST_OK;
          q_job.fill   = count_r;
        end
        default: begin
          q_push = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    rd_out_nxt = rd_out_r;
    if (q_push && q_job.is_read && !rd_done) begin
      rd_out_nxt = rd_out_r + 1'b1;
    end else if (rd_done && !(q_push && q_job.is_read)) begin
      rd_out_nxt = rd_out_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= LEN_RESET;
      ri_r      <= '0;
      wi_r      <= '0;
      tw_r      <= '0;
      count_r   <= '0;
      run_cnt_r <= '0;
      run_act_r <= 1'b0;
      run_ok_r  <= 1'b0;
      exit_r    <= 1'b0;
      rd_out_r  <= '0;
    end else begin
      len_r     <= len_nxt;
      ri_r      <= ri_nxt;
      wi_r      <= wi_nxt;
      tw_r      <= tw_nxt;
      count_r   <= count_nxt;
      run_cnt_r <= run_cnt_nxt;
      run_act_r <= run_act_nxt;
      run_ok_r  <= run_ok_nxt;
      exit_r    <= exit_nxt;
      rd_out_r  <= rd_out_nxt;
    end
  end

endmodule

@@ rtl/rbb_back.sv @@
// ----------------------------------------------------------------------------
// rbb_back
// Back end: takes jobs from the queue, streams read chunks out of the store
// one byte per cycle while not stalled, and holds each result in the output register.
// ----------------------------------------------------------------------------
module rbb_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [8:0]                        eff_len,
  input  logic                              q_valid,
  input  rbb_pkg::job_t                     q_job,
  output logic                              q_pop,
  output logic                              ram_rd_en,
  output logic [$clog2(rbb_pkg::DEPTH)-1:0] ram_rd_addr,
  input  logic [7:0]                        ram_rd_data,
  output logic                              rd_done,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_is_data,
  output logic [7:0]                        out_data_byte_res,
  output logic [2:0]                        out_status,
  output logic                              out_last_res,
  output logic [8:0]                        out_fill_level
);
  import rbb_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic       busy_r, busy_nxt;
  logic       pend_r, pend_nxt;
  logic       pend_last_r, pend_last_nxt;
  logic       oval_r, oval_nxt;
  logic [7:0] addr_r, addr_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [8:0] fill_r, fill_nxt;

  logic       is_data_r;
  logic [7:0] byte_r;
  status_t    status_r;
  logic       last_r;
  logic [8:0] olevel_r;

  logic       out_free;
  logic       load_data;
  logic       issue;
  logic       load_status;
  logic [8:0] addr_inc;

  assign out_free    = !oval_r || !out_stall;
  assign load_data   = pend_r && out_free;
  assign issue       = busy_r && (!pend_r || load_data);
  assign q_pop       = !busy_r && !pend_r && q_valid && (q_job.is_read || out_free);
  assign load_status = q_pop && !q_job.is_read;
  assign addr_inc    = {1'b0, addr_r} + 9'd1;

  assign ram_rd_en   = issue;
  assign ram_rd_addr = AW'(addr_r);
  assign rd_done     = issue && (rem_r == 8'd1);

  always_comb begin
    busy_nxt      = busy_r;
    addr_nxt      = addr_r;
    rem_nxt       = rem_r;
    fill_nxt      = fill_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    if (issue) begin
      pend_nxt      = 1'b1;
      pend_last_nxt = (rem_r == 8'd1);
      rem_nxt       = rem_r - 8'd1;
      addr_nxt      = (addr_inc >= eff_len) ? 8'd0 : addr_inc[7:0];
      busy_nxt      = (rem_r != 8'd1);
    end else if (load_data) begin
      pend_nxt = 1'b0;
    end
    if (q_pop && q_job.is_read) begin
      busy_nxt = 1'b1;
      addr_nxt = q_job.start;
      rem_nxt  = q_job.len;
      fill_nxt = q_job.fill;
    end
  end

  always_comb begin
    oval_nxt = oval_r;
    if (load_data || load_status) begin
      oval_nxt = 1'b1;
    end else if (!out_stall) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
      oval_r      <= 1'b0;
      rem_r       <= '0;
    end else begin
      busy_r      <= busy_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
      oval_r      <= oval_nxt;
      rem_r       <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    fill_r <= fill_nxt;
    if (load_data) begin
      is_data_r <= 1'b1;
      byte_r    <= ram_rd_data;
      status_r  <= ST_OK;
      last_r    <= pend_last_r;
      olevel_r  <= fill_r;
    end else if (load_status) begin
      is_data_r <= 1'b0;
      byte_r    <= '0;
      status_r  <= q_job.status;
      last_r    <= 1'b1;
      olevel_r  <= q_job.fill;
    end
  end

  assign out_valid         = oval_r;
  assign out_is_data       = is_data_r;
  assign out_data_byte_res = byte_r;
  assign out_status        = status_r;
  assign out_last_res      = last_r;
  assign out_fill_level    = olevel_r;

endmodule

@@ rtl/ring_byte_buffer_unit.sv @@
// Path: status results pass the job queue and output register; read bytes
//   pass the queue, store and output register, one per cycle unless stalled.
// Throughput: one item per cycle unless the queue is full; a write item waits
//   while read bytes are queued or streaming, since their slots count as free.
// Reset: synchronous, active low; clears indices, fill count, run and exit
//   state at once. Store contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
// ring_byte_buffer_unit
// Circular byte buffer with all-or-nothing chunk writes and reads, a front
// end that checks and stores, a job queue, and a back end that streams out.
// ----------------------------------------------------------------------------
module ring_byte_buffer_unit #(
  parameter int MAX_CHUNK = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_chunk_length,
  input  logic [7:0] in_data_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_is_data,
  output logic [7:0] out_data_byte_res,
  output logic [2:0] out_status,
  output logic       out_last_res,
  output logic [8:0] out_fill_level,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] cfg_data
);
  import rbb_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [8:0]    eff_len;
  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [7:0]    ram_wr_data;
  logic          ram_rd_en;
  logic [AW-1:0] ram_rd_addr;
  logic [7:0]    ram_rd_data;
  logic          q_push;
  job_t          q_push_job;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  job_t          q_head;
  logic          rd_done;

  rbb_front #(
    .MAX_CHUNK (MAX_CHUNK)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_chunk_length (in_chunk_length),
    .in_data_byte    (in_data_byte),
    .in_last         (in_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .eff_len         (eff_len),
    .ram_wr_en       (ram_wr_en),
    .ram_wr_addr     (ram_wr_addr),
    .ram_wr_data     (ram_wr_data),
    .q_push          (q_push),
    .q_job           (q_push_job),
    .q_full          (q_full),
    .rd_done         (rd_done)
  );

  rbb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (q_head)
  );

  rbb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  rbb_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .eff_len           (eff_len),
    .q_valid           (q_valid),
    .q_job             (q_head),
    .q_pop             (q_pop),
    .ram_rd_en         (ram_rd_en),
    .ram_rd_addr       (ram_rd_addr),
    .ram_rd_data       (ram_rd_data),
    .rd_done           (rd_done),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_is_data       (out_is_data),
    .out_data_byte_res (out_data_byte_res),
    .out_status        (out_status),
    .out_last_res      (out_last_res),
    .out_fill_level    (out_fill_level)
  );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ring byte buffer. Command items stream in from
// a queue under random gaps while the result side stalls at random. Every
// accepted item runs through a local model of the ring that queues the
// results it predicts. Each result leaving the block is checked against the
// oldest prediction. Buffer length writes happen between phases, only once
// the block has drained. The run ends in exit mode.
// ----------------------------------------------------------------------------
module tb;
  import rbb_pkg::*;

  localparam int MAX_CHUNK = 64;
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] len;
    logic [7:0] data;
    logic       last;
  } ring_op_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] data;
    status_t    status;
    logic       last;
    logic [8:0] fill;
  } ring_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_cmd = CMD_WRITE;
  logic [7:0] in_chunk_length = 8'd0;
  logic [7:0] in_data_byte = 8'd0;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_is_data;
  logic [7:0] out_data_byte_res;
  logic [2:0] out_status;
  logic       out_last_res;
  logic [8:0] out_fill_level;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [8:0] cfg_data = 9'd0;

  ring_byte_buffer_unit #(.MAX_CHUNK(MAX_CHUNK)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_chunk_length(in_chunk_length), .in_data_byte(in_data_byte),
    .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_is_data(out_is_data),
    .out_data_byte_res(out_data_byte_res), .out_status(out_status),
    .out_last_res(out_last_res), .out_fill_level(out_fill_level),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ring model state
  logic [7:0] ring_mem [DEPTH];
  int rd_idx, wr_idx, tent_idx, held, run_cnt, buf_len;
  bit run_on, run_good, exiting;

  ring_op_t     queued_ops[$];
  ring_result_t due_results[$];

  int unsigned queued_count, taken_count, results_seen, cfg_writes;
  int unsigned mismatches, commits, bytes_read, refusals;

  function automatic int next_slot(int i);
    return (i + 1 >= buf_len) ? 0 : i + 1;
  endfunction

  function automatic status_t refusal(int len, int room);
    if (len == 0) return ST_BAD_LEN;
    if (exiting) return ST_EXITING;
    if (len > buf_len || len > MAX_CHUNK) return ST_TOO_LONG;
    if (len > room) return ST_BLOCK;
    return ST_OK;
  endfunction

  function automatic void post_status(status_t st);
    ring_result_t r;
    r.is_data = 1'b0;
    r.data    = 8'd0;
    r.status  = st;
    r.last    = 1'b1;
    r.fill    = held[8:0];
    if (st != ST_OK) refusals++;
    due_results.push_back(r);
  endfunction

  function automatic void empty_ring();
    rd_idx = 0;
    wr_idx = 0;
    tent_idx = 0;
    held = 0;
    run_on = 0;
    run_good = 0;
    run_cnt = 0;
  endfunction

  function automatic void buffer_step(ring_op_t op);
    int len, room;
    status_t st;
    ring_result_t r;
    len = op.len;
    if (op.cmd == CMD_WRITE) begin
      room = buf_len - held;
      if (!run_on) begin
        run_on = 1;
        run_cnt = 0;
        tent_idx = wr_idx;
        run_good = 1;
      end
      if (run_good && refusal(len, room) == ST_OK && run_cnt < len) begin
        ring_mem[tent_idx] = op.data;
        tent_idx = next_slot(tent_idx);
      end else begin
        run_good = 0;
      end
      if (run_cnt < 255) run_cnt++;
      if (op.last) begin
        st = refusal(len, room);
        if (st == ST_OK && (run_cnt != len || !run_good)) st = ST_BAD_LEN;
        if (st == ST_OK) begin
          wr_idx = tent_idx;
          held += len;
          commits++;
        end
        run_on = 0;
        run_good = 0;
        run_cnt = 0;
        post_status(st);
      end
    end else begin
      run_on = 0;
      run_good = 0;
      run_cnt = 0;
      case (op.cmd)
        CMD_READ: begin
          st = refusal(len, held);
          if (st != ST_OK) begin
            post_status(st);
          end else begin
            held -= len;
            for (int k = 0; k < len; k++) begin
              r.is_data = 1'b1;
              r.data    = ring_mem[rd_idx];
              r.status  = ST_OK;
              r.last    = (k + 1 == len);
              r.fill    = held[8:0];
              due_results.push_back(r);
              rd_idx = next_slot(rd_idx);
              bytes_read++;
            end
          end
        end
        CMD_CLEAR: begin
          empty_ring();
          post_status(ST_OK);
        end
        default: begin
          exiting = 1;
          post_status(ST_OK);
        end
      endcase
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 30);
  endfunction

  // input driver
  int gap_left = 0;
  bit in_quiet = 0;
  ring_op_t launch;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (queued_ops.size() != 0) begin
        launch = queued_ops.pop_front();
        in_valid        <= 1'b1;
        in_cmd          <= launch.cmd;
        in_chunk_length <= launch.len;
        in_data_byte    <= launch.data;
        in_last         <= launch.last;
        if ($urandom_range(0, 39) == 0) in_quiet <= !in_quiet;
        gap_left <= in_quiet ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result-side backpressure
  int ostall_left = 0;
  bit out_quiet = 0;
  int ogap;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      ostall_left <= 0;
    end else if (ostall_left > 0) begin
      out_stall <= 1'b1;
      ostall_left <= ostall_left - 1;
    end else begin
      if ($urandom_range(0, 63) == 0) out_quiet <= !out_quiet;
      ogap = out_quiet ? 0 : pick_gap();
      out_stall <= (ogap != 0);
      ostall_left <= (ogap == 0) ? 0 : ogap - 1;
    end
  end

  // monitor and checker
  ring_result_t got, want;
  ring_op_t seen;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        got = {out_is_data, out_data_byte_res, out_status, out_last_res, out_fill_level};
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result is_data %0d byte %02h status %0d last %0d fill %0d",
                     $realtime, got.is_data, got.data, got.status, got.last, got.fill);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: result mismatch, got is_data %0d byte %02h status %0d last %0d",
                        " fill %0d, want is_data %0d byte %02h status %0d last %0d fill %0d"},
                       $realtime, got.is_data, got.data, got.status, got.last, got.fill,
                       want.is_data, want.data, want.status, want.last, want.fill);
          end
        end
      end
      if (in_valid && !in_stall) begin
        seen.cmd  = cmd_t'(in_cmd);
        seen.len  = in_chunk_length;
        seen.data = in_data_byte;
        seen.last = in_last;
        buffer_step(seen);
        taken_count++;
      end
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        if (cfg_data != 9'd0) begin
          buf_len = (cfg_data > DEPTH) ? DEPTH : cfg_data;
          empty_ring();
        end
      end
    end
  end

  // watchdog
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  task automatic add_op(cmd_t cmd, int len, int data, bit last);
    ring_op_t op;
    op.cmd  = cmd;
    op.len  = len[7:0];
    op.data = data[7:0];
    op.last = last;
    queued_ops.push_back(op);
    queued_count++;
  endtask

  task automatic add_chunk(int len, int count);
    for (int k = 0; k < count; k++)
      add_op(CMD_WRITE, len, $urandom_range(0, 255), k == count - 1);
  endtask

  function automatic int pick_len(int lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, (lim < 6) ? lim : 6);
    if (r < 95) return $urandom_range(1, (lim < 20) ? lim : 20);
    return $urandom_range(1, lim);
  endfunction

  task automatic random_mix(int n, int lim);
    int stop, r, len, k;
    stop = queued_count + n;
    while (queued_count < stop) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        len = pick_len(lim);
        add_chunk(len, len);
      end else if (r < 75) begin
        add_op(CMD_READ, pick_len(lim), $urandom_range(0, 255), 1'($urandom_range(0, 1)));
      end else if (r < 80) begin
        add_op(CMD_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255), 1'b1);
      end else if (r < 85) begin
        // miscounted chunk
        len = pick_len(lim);
        add_chunk(len, (len == 1 || $urandom_range(0, 1)) ? len + 1 : len - 1);
      end else if (r < 90) begin
        // drop a run midway
        len = pick_len(lim) + 1;
        k = $urandom_range(1, len - 1);
        for (int i = 0; i < k; i++)
          add_op(CMD_WRITE, len, $urandom_range(0, 255), 1'b0);
        add_op(($urandom_range(0, 1) != 0) ? CMD_READ : CMD_CLEAR, pick_len(lim),
               $urandom_range(0, 255), 1'b0);
      end else begin
        len = $urandom_range(0, 1) ? 0 : $urandom_range(lim + 1, 255);
        if (r < 95) add_chunk(len, 1);
        else add_op(CMD_READ, len, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic settle();
    while (taken_count != queued_count || due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_length(int value);
    settle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value[8:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    buf_len = DEPTH;
    exiting = 0;
    empty_ring();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed, full-size ring
    add_op(CMD_WRITE, 0, 8'hff, 1'b1);
    add_op(CMD_WRITE, 255, 8'hff, 1'b1);
    add_op(CMD_WRITE, MAX_CHUNK + 1, 8'h00, 1'b1);
    add_op(CMD_WRITE, 3, 8'h00, 1'b0);
    add_op(CMD_WRITE, 3, 8'hff, 1'b0);
    add_op(CMD_WRITE, 3, 8'ha5, 1'b1);
    add_chunk(3, 2);
    add_chunk(2, 3);
    add_op(CMD_READ, 0, 8'h00, 1'b0);
    add_op(CMD_READ, 255, 8'hff, 1'b1);
    add_op(CMD_READ, 4, 8'h00, 1'b0);
    add_op(CMD_READ, 3, 8'h00, 1'b1);
    add_op(CMD_READ, 1, 8'h00, 1'b0);
    add_op(CMD_WRITE, 4, 8'h5a, 1'b0);
    add_op(CMD_WRITE, 4, 8'h5a, 1'b0);
    add_op(CMD_CLEAR, 0, 8'h00, 1'b0);
    add_chunk(1, 1);
    add_op(CMD_READ, 1, 8'h00, 1'b1);

    // one-byte ring
    write_length(1);
    add_chunk(1, 1);
    add_chunk(1, 1);
    add_chunk(2, 2);
    add_op(CMD_READ, 1, 8'h00, 1'b0);
    add_op(CMD_READ, 1, 8'h00, 1'b0);
    add_op(CMD_READ, 2, 8'h00, 1'b0);
    random_mix(20, 1);

    // oversize value clamps to the full store
    write_length(511);
    add_chunk(MAX_CHUNK, MAX_CHUNK);
    add_op(CMD_READ, MAX_CHUNK, 8'h00, 1'b0);
    random_mix(70, MAX_CHUNK);

    // zero is ignored, contents stay
    write_length(0);
    random_mix(25, MAX_CHUNK);

    write_length(40);
    random_mix(60, 40);

    write_length(200);
    random_mix(50, MAX_CHUNK);

    // exit mode, kept to the end
    settle();
    add_op(CMD_EXIT, 0, 8'h00, 1'b1);
    add_chunk(2, 2);
    add_op(CMD_READ, 1, 8'h00, 1'b0);
    add_chunk(0, 1);
    add_op(CMD_CLEAR, 0, 8'h00, 1'b0);
    random_mix(10, MAX_CHUNK);

    settle();
    $display("run covered %0d input transfers, %0d results, %0d length writes",
             taken_count, results_seen, cfg_writes);
    $display("chunks committed %0d, bytes read back %0d, refused commands %0d",
             commits, bytes_read, refusals);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
